// ----- sv/graph_cut_vertex_and_bridge_finder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the graph cut-vertex and bridge finder.
// Every assertion is clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef GRAPH_CUT_VERTEX_AND_BRIDGE_FINDER_MACROS_SVH
`define GRAPH_CUT_VERTEX_AND_BRIDGE_FINDER_MACROS_SVH
`ifndef NO_ASSERTIONS
// A condition that must hold at every clock edge.
`define GCVB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// A condition that must hold in the cycle after a trigger.
`define GCVB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GCVB_ASSERT(lbl, cond, msg)
`define GCVB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/gcvb_pkg.sv -----
// ----------------------------------------------------------------------------
// gcvb_pkg
// Sizes, codes, states and bit helpers of the cut-vertex and bridge finder.
// ----------------------------------------------------------------------------
package gcvb_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int EADDR_W      = $clog2(MAX_EDGES);
  localparam int ECNT_W       = $clog2(MAX_EDGES + 1);

  // Operation codes of an input item.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_VCOUNT = 1'b1;

  // Analysis modes.
  localparam logic MODE_CUT    = 1'b0;
  localparam logic MODE_BRIDGE = 1'b1;

  typedef logic [MAX_VERTICES-1:0] vset_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RA,
    ST_ADD_WA,
    ST_ADD_RB,
    ST_ADD_WB,
    ST_SEED,
    ST_POP,
    ST_EXPAND,
    ST_DONE,
    ST_EFETCH,
    ST_EWAIT,
    ST_FINISH
  } state_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [VIDX_W-1:0] lowest_idx(input vset_t v);
    logic [VIDX_W-1:0] r;
    r = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = VIDX_W'(i);
      end
    end
    return r;
  endfunction

  // Mask of the first n vertices.
  function automatic vset_t first_n(input logic [VIDX_W:0] n);
    vset_t m;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = ((VIDX_W + 1)'(i) < n);
    end
    return m;
  endfunction

endpackage

// ----- sv/gcvb_ifs.sv -----
// ----------------------------------------------------------------------------
// gcvb channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface gcvb_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [6:0] end_a;
  logic [6:0] end_b;
  modport source (output valid, output operation, output end_a, output end_b, input ready);
  modport sink (input valid, input operation, input end_a, input end_b, output ready);
endinterface

interface gcvb_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] cut_vertex;
  logic [8:0] bridge_total;
  logic       none_found;
  logic       edges_dropped;
  logic       last_result;
  modport source (output valid, output cut_vertex, output bridge_total, output none_found,
                  output edges_dropped, output last_result, input ready);
  modport sink (input valid, input cut_vertex, input bridge_total, input none_found,
                input edges_dropped, input last_result, output ready);
endinterface

// ----- sv/gcvb_ram.sv -----
// ----------------------------------------------------------------------------
// gcvb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcvb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/graph_cut_vertex_and_bridge_finder.sv -----
// ----------------------------------------------------------------------------
// graph_cut_vertex_and_bridge_finder
// Holds an undirected graph as an adjacency bit matrix plus an edge list and
// finds cut vertices or counts bridges by repeated component counting.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// items     in   operation, end_a, end_b
// results   out  cut_vertex, bridge_total, none_found, edges_dropped, last_result
// cfg_*     in   write enable, register index, write data
//
// Add does two read-modify-writes of matrix rows, first row A, then row B.
// An analysis does one component count per vertex or per listed edge after a
// base count. Each count seeds every component and pops and expands every
// vertex reached; a bridge analysis first fetches each listed edge. All of it
// goes through the one matrix read port and the lowest-bit search; ready stays
// low until it ends. Clear empties the matrix at once through per-row valid bits.
// A stalled result port holds the sequencer only when the next result is due.
// ----------------------------------------------------------------------------
`include "graph_cut_vertex_and_bridge_finder_macros.svh"

module graph_cut_vertex_and_bridge_finder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [6:0]            cfg_data,
  gcvb_item_if.sink             items,
  gcvb_result_if.source         results
);

  localparam int VW = gcvb_pkg::VIDX_W;
  localparam int NV = gcvb_pkg::MAX_VERTICES;

  gcvb_pkg::state_t state, state_next;

  // Configuration registers.
  logic       analysis_mode;
  logic [6:0] vertex_count;

  // Graph storage control.
  logic [NV-1:0]                   rows_valid;
  logic [gcvb_pkg::ECNT_W-1:0]     edges_held;
  logic                            overflow;

  // Analysis registers.
  logic                            mode_r;
  logic [VW:0]                     n_r;
  logic                            base_phase;
  logic                            drop_r;
  gcvb_pkg::vset_t                 seen;
  gcvb_pkg::vset_t                 pending;
  logic [VW:0]                     cnt;
  logic [VW:0]                     base_cnt;
  logic [VW-1:0]                   cur_u;
  logic [VW-1:0]                   ea;
  logic [VW-1:0]                   eb;
  logic [VW-1:0]                   vi;
  logic [gcvb_pkg::ECNT_W-1:0]     k;
  logic [8:0]                      total;
  logic [VW-1:0]                   held;
  logic                            have_held;

  // Result register.
  logic       out_valid;
  logic [6:0] o_cut;
  logic [8:0] o_total;
  logic       o_none;
  logic       o_drop;
  logic       o_last;

  // Memory ports.
  logic                          adj_we;
  logic [VW-1:0]                 adj_raddr;
  gcvb_pkg::vset_t               adj_wdata;
  gcvb_pkg::vset_t               adj_q;
  logic                          es_we;
  logic [13:0]                   es_q;

  // Combinational helpers.
  logic            in_fire;
  logic            ends_ok;
  logic            list_full;
  logic            slot_free;
  logic            out_load;
  logic            raise;
  logic            emit_mid;
  logic            cut_edge;
  logic            vi_last;
  gcvb_pkg::vset_t row_eff;
  gcvb_pkg::vset_t fresh;
  gcvb_pkg::vset_t cand;
  logic [VW-1:0]   pop_idx;
  logic [VW-1:0]   seed_idx;
  logic [VW:0]     n_sat;

  assign in_fire   = items.valid && items.ready;
  assign ends_ok   = (items.end_a != 7'd0) && (items.end_a <= 7'(NV)) &&
                     (items.end_b != 7'd0) && (items.end_b <= 7'(NV));
  assign list_full = (edges_held >= gcvb_pkg::ECNT_W'(gcvb_pkg::MAX_EDGES));
  assign slot_free = !out_valid || results.ready;
  assign raise     = (cnt > base_cnt);
  assign cut_edge  = (mode_r == gcvb_pkg::MODE_BRIDGE) && !base_phase;
  assign vi_last   = ({1'b0, vi} == n_r - (VW + 1)'(1));
  assign emit_mid  = !base_phase && (mode_r == gcvb_pkg::MODE_CUT) && raise && have_held;
  assign n_sat     = (vertex_count > 7'(NV)) ? (VW + 1)'(NV) : (VW + 1)'(vertex_count);
  assign cand      = ~seen & gcvb_pkg::first_n(n_r);
  assign pop_idx   = gcvb_pkg::lowest_idx(pending);
  assign seed_idx  = gcvb_pkg::lowest_idx(cand);
  assign fresh     = row_eff & ~seen;

  // A new result enters the output register in this cycle.
  assign out_load  = ((state == gcvb_pkg::ST_DONE) && emit_mid && slot_free) ||
                     ((state == gcvb_pkg::ST_FINISH) && slot_free);

  // Row as last read, with empty rows and the edge under test taken out.
  always_comb begin
    row_eff = rows_valid[cur_u] ? adj_q : '0;
    if (cut_edge) begin
      if (cur_u == ea) begin
        row_eff[eb] = 1'b0;
      end
      if (cur_u == eb) begin
        row_eff[ea] = 1'b0;
      end
    end
  end

  // Adjacency matrix rows.
  gcvb_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (cur_u),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_q)
  );

  // Edge list, end_a above end_b.
  gcvb_ram #(.WIDTH(14), .DEPTH(gcvb_pkg::MAX_EDGES)) u_edges (
    .clk   (clk),
    .we    (es_we),
    .waddr (edges_held[gcvb_pkg::EADDR_W-1:0]),
    .wdata ({items.end_a, items.end_b}),
    .raddr (k[gcvb_pkg::EADDR_W-1:0]),
    .rdata (es_q)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcvb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory strobes.
  always_comb begin
    state_next  = state;
    items.ready = 1'b0;
    adj_we      = 1'b0;
    adj_raddr   = pop_idx;
    adj_wdata   = '0;
    es_we       = 1'b0;
    case (state)
      gcvb_pkg::ST_IDLE: begin
        items.ready = 1'b1;
        if (items.valid) begin
          if (items.operation == gcvb_pkg::OP_ADD && ends_ok && !list_full) begin
            es_we      = 1'b1;
            state_next = gcvb_pkg::ST_ADD_RA;
          end else if (items.operation == gcvb_pkg::OP_RUN) begin
            state_next = gcvb_pkg::ST_SEED;
          end
        end
      end
      gcvb_pkg::ST_ADD_RA: begin
        adj_raddr  = ea;
        state_next = gcvb_pkg::ST_ADD_WA;
      end
      gcvb_pkg::ST_ADD_WA: begin
        adj_we     = 1'b1;
        adj_wdata  = row_eff | (gcvb_pkg::vset_t'(1) << eb);
        state_next = gcvb_pkg::ST_ADD_RB;
      end
      gcvb_pkg::ST_ADD_RB: begin
        adj_raddr  = eb;
        state_next = gcvb_pkg::ST_ADD_WB;
      end
      gcvb_pkg::ST_ADD_WB: begin
        adj_we     = 1'b1;
        adj_wdata  = row_eff | (gcvb_pkg::vset_t'(1) << ea);
        state_next = gcvb_pkg::ST_IDLE;
      end
      gcvb_pkg::ST_SEED: begin
        state_next = (cand == '0) ? gcvb_pkg::ST_DONE : gcvb_pkg::ST_POP;
      end
      gcvb_pkg::ST_POP: begin
        state_next = (pending == '0) ? gcvb_pkg::ST_SEED : gcvb_pkg::ST_EXPAND;
      end
      gcvb_pkg::ST_EXPAND: begin
        state_next = gcvb_pkg::ST_POP;
      end
      gcvb_pkg::ST_DONE: begin
        if (base_phase) begin
          if (mode_r == gcvb_pkg::MODE_BRIDGE) begin
            state_next = gcvb_pkg::ST_EFETCH;
          end else if (n_r == '0) begin
            state_next = gcvb_pkg::ST_FINISH;
          end else begin
            state_next = gcvb_pkg::ST_SEED;
          end
        end else if (mode_r == gcvb_pkg::MODE_BRIDGE) begin
          state_next = gcvb_pkg::ST_EFETCH;
        end else if (emit_mid && !slot_free) begin
          state_next = gcvb_pkg::ST_DONE;
        end else if (vi_last) begin
          state_next = gcvb_pkg::ST_FINISH;
        end else begin
          state_next = gcvb_pkg::ST_SEED;
        end
      end
      gcvb_pkg::ST_EFETCH: begin
        state_next = (k >= edges_held) ? gcvb_pkg::ST_FINISH : gcvb_pkg::ST_EWAIT;
      end
      gcvb_pkg::ST_EWAIT: begin
        state_next = gcvb_pkg::ST_SEED;
      end
      gcvb_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_next = gcvb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gcvb_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, graph control and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      analysis_mode <= gcvb_pkg::MODE_CUT;
      vertex_count  <= 7'(NV);
      rows_valid    <= '0;
      edges_held    <= '0;
      overflow      <= 1'b0;
      out_valid     <= 1'b0;
      n_r           <= '0;
      seen          <= '0;
      pending       <= '0;
      cnt           <= '0;
      base_phase    <= 1'b0;
      have_held     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gcvb_pkg::CFG_MODE:   analysis_mode <= cfg_data[0];
          gcvb_pkg::CFG_VCOUNT: vertex_count  <= cfg_data;
          default: ;
        endcase
      end
      // The output register empties on a transfer unless a new result replaces it.
      if (results.valid && results.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        gcvb_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (items.operation == gcvb_pkg::OP_ADD && ends_ok) begin
              if (list_full) begin
                overflow <= 1'b1;
              end else begin
                edges_held <= edges_held + gcvb_pkg::ECNT_W'(1);
                ea         <= VW'(items.end_a - 7'd1);
                eb         <= VW'(items.end_b - 7'd1);
              end
            end else if (items.operation == gcvb_pkg::OP_CLEAR) begin
              rows_valid <= '0;
              edges_held <= '0;
              overflow   <= 1'b0;
            end else if (items.operation == gcvb_pkg::OP_RUN) begin
              mode_r     <= analysis_mode;
              n_r        <= n_sat;
              drop_r     <= overflow;
              base_phase <= 1'b1;
              have_held  <= 1'b0;
              total      <= '0;
              seen       <= '0;
              pending    <= '0;
              cnt        <= '0;
            end
          end
        end
        gcvb_pkg::ST_ADD_RA: begin
          cur_u <= ea;
        end
        gcvb_pkg::ST_ADD_WA: begin
          rows_valid[cur_u] <= 1'b1;
        end
        gcvb_pkg::ST_ADD_RB: begin
          cur_u <= eb;
        end
        gcvb_pkg::ST_ADD_WB: begin
          rows_valid[cur_u] <= 1'b1;
        end
        gcvb_pkg::ST_SEED: begin
          if (cand != '0) begin
            cnt               <= cnt + (VW + 1)'(1);
            seen[seed_idx]    <= 1'b1;
            pending[seed_idx] <= 1'b1;
          end
        end
        gcvb_pkg::ST_POP: begin
          if (pending != '0) begin
            pending[pop_idx] <= 1'b0;
            cur_u            <= pop_idx;
          end
        end
        gcvb_pkg::ST_EXPAND: begin
          seen    <= seen | fresh;
          pending <= pending | fresh;
        end
        gcvb_pkg::ST_DONE: begin
          if (base_phase) begin
            base_cnt   <= cnt;
            base_phase <= 1'b0;
            k          <= '0;
            vi         <= '0;
            seen       <= gcvb_pkg::vset_t'(1);
            pending    <= '0;
            cnt        <= '0;
          end else if (mode_r == gcvb_pkg::MODE_BRIDGE) begin
            if (raise && total != 9'd511) begin
              total <= total + 9'd1;
            end
            k <= k + gcvb_pkg::ECNT_W'(1);
          end else if (!(emit_mid && !slot_free)) begin
            if (raise) begin
              held      <= vi;
              have_held <= 1'b1;
            end
            if (emit_mid) begin
              out_valid <= 1'b1;
              o_cut     <= 7'(held) + 7'd1;
              o_total   <= '0;
              o_none    <= 1'b0;
              o_drop    <= drop_r;
              o_last    <= 1'b0;
            end
            vi      <= vi + VW'(1);
            seen    <= gcvb_pkg::vset_t'(1) << (vi + VW'(1));
            pending <= '0;
            cnt     <= '0;
          end
        end
        gcvb_pkg::ST_EWAIT: begin
          ea      <= VW'(es_q[13:7] - 7'd1);
          eb      <= VW'(es_q[6:0] - 7'd1);
          seen    <= '0;
          pending <= '0;
          cnt     <= '0;
        end
        gcvb_pkg::ST_FINISH: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            o_drop    <= drop_r;
            o_last    <= 1'b1;
            if (mode_r == gcvb_pkg::MODE_BRIDGE) begin
              o_cut   <= '0;
              o_total <= total;
              o_none  <= 1'b0;
            end else begin
              o_cut   <= have_held ? 7'(held) + 7'd1 : 7'd0;
              o_total <= '0;
              o_none  <= !have_held;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result channel.
  assign results.valid         = out_valid;
  assign results.cut_vertex    = o_cut;
  assign results.bridge_total  = o_total;
  assign results.none_found    = o_none;
  assign results.edges_dropped = o_drop;
  assign results.last_result   = o_last;

  // Checks on the walk and the graph store.
  `GCVB_ASSERT(a_pending_seen, (pending & ~seen) == '0, "pending vertex not marked seen")
  `GCVB_ASSERT(a_edges_cap, edges_held <= gcvb_pkg::ECNT_W'(gcvb_pkg::MAX_EDGES), "edge count high")
  `GCVB_ASSERT(a_cnt_bound, state == gcvb_pkg::ST_IDLE || cnt <= n_r, "component count too high")
  `GCVB_ASSERT_NEXT(a_clear, in_fire && items.operation == gcvb_pkg::OP_CLEAR, rows_valid == '0 && edges_held == '0, "clear left graph state")

endmodule
